/* rtl/spq_pkg.sv */
// ----------------------------------------------------------------------------
// spq_pkg
// Shared types and constants for the sorted minimum priority queue.
// ----------------------------------------------------------------------------
package spq_pkg;

    localparam int DATA_W = 32;
    localparam int OCC_W  = 5;

    localparam logic FUNC_INSERT = 1'b0;
    localparam logic FUNC_REMOVE = 1'b1;

    // Command beat
    typedef struct packed {
        logic                     func;
        logic signed [DATA_W-1:0] value;
    } t_cmd;

    // Result beat
    typedef struct packed {
        logic signed [DATA_W-1:0] removed_value;
        logic                     removed_valid;
        logic                     insert_rejected;
        logic [OCC_W-1:0]         occupancy;
    } t_result;

    // Per-cycle control broadcast to every cell
    typedef struct packed {
        logic ins;
        logic rem;
    } t_cell_ctrl;

endpackage

/* rtl/spq_cell.sv */
// ----------------------------------------------------------------------------
// spq_cell
// One slot of the sorted chain: holds a value and its valid bit, compares
// against the broadcast value and shifts with its neighbors.
// ----------------------------------------------------------------------------
module spq_cell (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  spq_pkg::t_cell_ctrl               i_ctrl,
    input  logic signed [spq_pkg::DATA_W-1:0] i_value,
    input  logic signed [spq_pkg::DATA_W-1:0] i_left_data,
    input  logic                              i_left_valid,
    input  logic                              i_left_take,
    input  logic signed [spq_pkg::DATA_W-1:0] i_right_data,
    input  logic                              i_right_valid,
    output logic signed [spq_pkg::DATA_W-1:0] o_data,
    output logic                              o_valid,
    output logic                              o_take
);

    logic signed [spq_pkg::DATA_W-1:0] r_data;
    logic signed [spq_pkg::DATA_W-1:0] n_data;
    logic                              r_valid;
    logic                              n_valid;

    // Take: this slot is at or past the insertion point (new value goes
    // after equal values, so strictly-less only).
    assign o_take  = !r_valid || (i_value < r_data);
    assign o_data  = r_data;
    assign o_valid = r_valid;

    always_comb begin
        n_data  = r_data;
        n_valid = r_valid;
        priority if (i_ctrl.ins) begin
            if (o_take) begin
                n_data  = i_left_take ? i_left_data : i_value;
                n_valid = r_valid | i_left_valid;
            end
        end else if (i_ctrl.rem) begin
            n_data  = i_right_data;
            n_valid = i_right_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

endmodule

/* rtl/sorted_min_priority_queue_core.sv */
// ----------------------------------------------------------------------------
// sorted_min_priority_queue_core
// Sorted minimum priority queue built as a chain of compare-and-shift cells.
// ----------------------------------------------------------------------------
// Takes one command per clock: busy is always low, so a command is accepted at
// every edge where start is high. Insert places the value in sorted order
// (after equal values); remove hands out the smallest value. Each command gives
// exactly one result beat, shown on o_result with o_done high for a single
// cycle, registered at the accepting edge; the receiver cannot hold it off.
// Each command is resolved by the per-cell compare of the broadcast value
// against every slot in parallel plus one neighbor shift. An insert into a
// full queue is dropped and flagged; a remove from an empty queue returns
// removed_valid low. Occupancy reports the count after the command, modulo 32.
module sorted_min_priority_queue_core #(
    parameter int CAPACITY = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  spq_pkg::t_cmd        i_cmd,
    output logic                 o_done,
    output spq_pkg::t_result     o_result
);

    localparam int CW = $clog2(CAPACITY + 1);

    logic                              w_accept;
    logic                              w_full;
    logic                              w_empty;
    spq_pkg::t_cell_ctrl               w_ctrl;
    logic signed [spq_pkg::DATA_W-1:0] w_data  [CAPACITY];
    logic [CAPACITY-1:0]               w_valid;
    logic [CAPACITY-1:0]               w_take;

    logic [CW-1:0]                     r_count;
    logic [CW-1:0]                     n_count;
    logic                              r_done;
    spq_pkg::t_result                  r_result;
    spq_pkg::t_result                  n_result;

    assign busy     = 1'b0;
    assign w_accept = start && !busy;
    assign w_full   = (r_count == CW'(CAPACITY));
    assign w_empty  = (r_count == '0);

    assign w_ctrl.ins = w_accept && (i_cmd.func == spq_pkg::FUNC_INSERT) && !w_full;
    assign w_ctrl.rem = w_accept && (i_cmd.func == spq_pkg::FUNC_REMOVE) && !w_empty;

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++) begin : g_cell
            logic signed [spq_pkg::DATA_W-1:0] w_ldata;
            logic                              w_lvalid;
            logic                              w_ltake;
            logic signed [spq_pkg::DATA_W-1:0] w_rdata;
            logic                              w_rvalid;

            if (g == 0) begin : g_head
                assign w_ldata  = '0;
                assign w_lvalid = 1'b1;
                assign w_ltake  = 1'b0;
            end else begin : g_mid
                assign w_ldata  = w_data[g-1];
                assign w_lvalid = w_valid[g-1];
                assign w_ltake  = w_take[g-1];
            end

            if (g == CAPACITY - 1) begin : g_tail
                assign w_rdata  = '0;
                assign w_rvalid = 1'b0;
            end else begin : g_body
                assign w_rdata  = w_data[g+1];
                assign w_rvalid = w_valid[g+1];
            end

            spq_cell u_cell (
                .i_clk         (i_clk),
                .i_rst_n       (i_rst_n),
                .i_ctrl        (w_ctrl),
                .i_value       (i_cmd.value),
                .i_left_data   (w_ldata),
                .i_left_valid  (w_lvalid),
                .i_left_take   (w_ltake),
                .i_right_data  (w_rdata),
                .i_right_valid (w_rvalid),
                .o_data        (w_data[g]),
                .o_valid       (w_valid[g]),
                .o_take        (w_take[g])
            );
        end
    endgenerate

    always_comb begin
        n_count = r_count;
        if (w_ctrl.ins) begin
            n_count = r_count + CW'(1);
        end else if (w_ctrl.rem) begin
            n_count = r_count - CW'(1);
        end

        n_result.removed_value   = w_ctrl.rem ? w_data[0] : '0;
        n_result.removed_valid   = w_ctrl.rem;
        n_result.insert_rejected = (i_cmd.func == spq_pkg::FUNC_INSERT) && w_full;
        n_result.occupancy       = spq_pkg::OCC_W'(n_count);
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_result <= n_result;
        end
        if (!i_rst_n) begin
            r_count <= '0;
            r_done  <= 1'b0;
        end else begin
            r_count <= n_count;
            r_done  <= w_accept;
        end
    end

    assign o_done   = r_done;
    assign o_result = r_result;

`ifndef NO_ASSERTIONS
    a_count_matches_cells: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(w_valid) == int'(r_count))
        else $error("count differs from occupied cells");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("count above capacity");

    a_one_result_per_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> o_done)
        else $error("accepted beat gave no result");

    a_no_spurious_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_accept |=> !o_done)
        else $error("result without accepted beat");

    a_flags_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !(o_result.removed_valid && o_result.insert_rejected))
        else $error("remove and reject flagged together");
`endif

endmodule

/* tb/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the sorted minimum priority queue core.
// ----------------------------------------------------------------------------
// Drives insert and remove commands with random gaps and predicts each result
// beat from a behavioral copy of the sorted store. Every result beat is
// checked field by field against the oldest prediction in order. A directed
// opening hits the value extremes, equal values, a full queue and an empty
// queue. Random phases then push the queue toward full, toward empty or keep
// it balanced.
// ----------------------------------------------------------------------------

class min_queue_scoreboard #(int DEPTH = 16);
    logic signed [spq_pkg::DATA_W-1:0] slots[DEPTH];
    int                                held;
    spq_pkg::t_result                  pending_results[$];
    int                                error_count;
    int                                n_inserts;
    int                                n_removes;
    int                                n_rejected;
    int                                n_empty_removes;
    int                                n_full_hits;

    function new();
        held            = 0;
        error_count     = 0;
        n_inserts       = 0;
        n_removes       = 0;
        n_rejected      = 0;
        n_empty_removes = 0;
        n_full_hits     = 0;
    endfunction

    // Apply one accepted command to the shadow store and queue its result.
    function void note_command(spq_pkg::t_cmd cmd);
        spq_pkg::t_result res;
        int               pos;
        res = '0;
        if (cmd.func == spq_pkg::FUNC_INSERT) begin
            n_inserts++;
            if (held >= DEPTH) begin
                res.insert_rejected = 1'b1;
                n_rejected++;
            end else begin
                // New value lands after any equal ones.
                pos = held;
                while (pos > 0 && cmd.value < slots[pos-1]) begin
                    slots[pos] = slots[pos-1];
                    pos--;
                end
                slots[pos] = cmd.value;
                held++;
                if (held == DEPTH)
                    n_full_hits++;
            end
        end else begin
            n_removes++;
            if (held > 0) begin
                res.removed_value = slots[0];
                res.removed_valid = 1'b1;
                for (int i = 1; i < held; i++)
                    slots[i-1] = slots[i];
                held--;
            end else begin
                n_empty_removes++;
            end
        end
        res.occupancy = spq_pkg::OCC_W'(held);
        pending_results.push_back(res);
    endfunction

    function void check_beat(spq_pkg::t_result got);
        spq_pkg::t_result want;
        if (pending_results.size() == 0) begin
            $error("result beat with no command outstanding");
            error_count++;
            return;
        end
        want = pending_results.pop_front();
        if (got.removed_value !== want.removed_value) begin
            $error("removed_value: expected %0d, got %0d",
                   want.removed_value, got.removed_value);
            error_count++;
        end
        if (got.removed_valid !== want.removed_valid) begin
            $error("removed_valid: expected %0b, got %0b",
                   want.removed_valid, got.removed_valid);
            error_count++;
        end
        if (got.insert_rejected !== want.insert_rejected) begin
            $error("insert_rejected: expected %0b, got %0b",
                   want.insert_rejected, got.insert_rejected);
            error_count++;
        end
        if (got.occupancy !== want.occupancy) begin
            $error("occupancy: expected %0d, got %0d",
                   want.occupancy, got.occupancy);
            error_count++;
        end
    endfunction
endclass

module tb;

    localparam int QUEUE_DEPTH   = 16;
    localparam int RANDOM_ITEMS  = 1400;
    localparam int STALL_LIMIT   = 2000;
    localparam int DRAIN_CYCLES  = 4;
    localparam int DW            = spq_pkg::DATA_W;

    logic             i_clk;
    logic             i_rst_n;
    logic             start;
    logic             busy;
    spq_pkg::t_cmd    i_cmd;
    logic             o_done;
    spq_pkg::t_result o_result;

    min_queue_scoreboard #(QUEUE_DEPTH) sb;
    int idle_cycles;

    sorted_min_priority_queue_core #(
        .CAPACITY(QUEUE_DEPTH)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_cmd   (i_cmd),
        .o_done  (o_done),
        .o_result(o_result)
    );

    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    // Monitor: check the result beat first, then log the command accepted here.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_done)
                sb.check_beat(o_result);
            if (start && !busy)
                sb.note_command(i_cmd);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && ((start && !busy) || o_done)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= STALL_LIMIT) begin
            $display("FAIL sorted_min_priority_queue_core");
            $finish;
        end
    end

    function automatic int pick_gap(bit burst);
        int r;
        r = $urandom_range(0, 99);
        if (burst || r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(4, 40);
    endfunction

    function automatic logic signed [DW-1:0] pick_value();
        case ($urandom_range(0, 9))
            0: return {1'b1, {(DW-1){1'b0}}};
            1: return {1'b0, {(DW-1){1'b1}}};
            2, 3, 4: return DW'(int'($urandom_range(0, 8)) - 4);
            default: return $urandom();
        endcase
    endfunction

    // Present one command, hold it until taken, then idle for gap cycles.
    task automatic send_command(logic func, logic signed [DW-1:0] value,
                                int gap);
        start <= 1'b1;
        i_cmd <= '{func: func, value: value};
        do @(posedge i_clk); while (busy !== 1'b0);
        if (gap > 0) begin
            start <= 1'b0;
            i_cmd <= {1'($urandom_range(0, 1)), 32'($urandom())};
            repeat (gap) @(posedge i_clk);
        end
    endtask

    initial begin
        int  insert_pct;
        int  phase_left;
        bit  burst;
        logic signed [DW-1:0] fill_value;

        sb          = new();
        i_rst_n     = 1'b0;
        start       = 1'b0;
        i_cmd       = '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: empty remove, extremes, duplicates, fill to full, overflow.
        send_command(spq_pkg::FUNC_REMOVE, 32'sd0, pick_gap(1'b0));
        send_command(spq_pkg::FUNC_INSERT, {1'b0, {(DW-1){1'b1}}}, 0);
        send_command(spq_pkg::FUNC_INSERT, {1'b1, {(DW-1){1'b0}}}, 0);
        send_command(spq_pkg::FUNC_INSERT, 32'sd0, pick_gap(1'b0));
        send_command(spq_pkg::FUNC_INSERT, -32'sd1, 0);
        send_command(spq_pkg::FUNC_INSERT, 32'sd1, 0);
        send_command(spq_pkg::FUNC_INSERT, 32'sd5, 0);
        send_command(spq_pkg::FUNC_INSERT, 32'sd5, pick_gap(1'b0));
        for (int i = 0; i < QUEUE_DEPTH - 7; i++) begin
            fill_value = $urandom();
            send_command(spq_pkg::FUNC_INSERT, fill_value, pick_gap(1'b0));
        end
        send_command(spq_pkg::FUNC_INSERT, {1'b1, {(DW-1){1'b0}}}, 0);
        send_command(spq_pkg::FUNC_INSERT, {1'b0, {(DW-1){1'b1}}}, 0);
        send_command(spq_pkg::FUNC_REMOVE, 32'sd0, 0);
        send_command(spq_pkg::FUNC_REMOVE, $urandom(), pick_gap(1'b0));

        // Random phases: fill-heavy, drain-heavy or balanced.
        phase_left = 0;
        insert_pct = 50;
        burst      = 1'b0;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (phase_left == 0) begin
                phase_left = $urandom_range(10, 60);
                case ($urandom_range(0, 2))
                    0: insert_pct = 85;
                    1: insert_pct = 15;
                    default: insert_pct = 50;
                endcase
                burst = ($urandom_range(0, 3) == 0);
            end
            phase_left--;
            send_command(($urandom_range(0, 99) < insert_pct) ?
                             spq_pkg::FUNC_INSERT : spq_pkg::FUNC_REMOVE,
                         pick_value(), pick_gap(burst));
        end
        start <= 1'b0;

        while (sb.pending_results.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Covered %0d inserts (%0d rejected on full, full reached %0d times)",
                 sb.n_inserts, sb.n_rejected, sb.n_full_hits);
        $display("and %0d removes (%0d on an empty queue)",
                 sb.n_removes, sb.n_empty_removes);
        if (sb.error_count == 0 && sb.pending_results.size() == 0) begin
            $display("PASS sorted_min_priority_queue_core");
        end else begin
            $display("FAIL sorted_min_priority_queue_core");
        end
        $finish;
    end
endmodule
